### hw/rtl/iidl_pkg.sv
package iidl_pkg;

    // List capacity and stored entry width.
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;

    // Fixed field widths of the request and result beats.
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int RDATA_W  = 32;
    localparam int COUNT_W  = 5;

    // Internal widths. Only the low bits of the value field can ever be stored,
    // so an entry never needs to be wider than the value field.
    localparam int STORE_W = (DATA_W < VALUE_W) ? DATA_W : VALUE_W;
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_SELECT = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;  // capture the request beat
        logic exec;   // check, commit and register the result
    } t_cmd;

endpackage

### hw/rtl/iidl_ctrl.sv
module iidl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output iidl_pkg::t_cmd o_cmd
);
    import iidl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_cmd.latch = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

### hw/rtl/iidl_dp.sv
module iidl_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  iidl_pkg::t_cmd                 i_cmd,
    input  logic [iidl_pkg::FUNC_W-1:0]    i_func,
    input  logic [iidl_pkg::POS_W-1:0]     i_position,
    input  logic [iidl_pkg::VALUE_W-1:0]   i_value,
    output logic [iidl_pkg::STATUS_W-1:0]  o_status,
    output logic [iidl_pkg::RDATA_W-1:0]   o_read_data,
    output logic [iidl_pkg::COUNT_W-1:0]   o_count
);
    import iidl_pkg::*;

    // Captured request.
    t_op                r_op;
    logic [POS_W-1:0]   r_pos;
    logic [STORE_W-1:0] r_val;

    // List storage and fill level.
    logic [STORE_W-1:0] r_entries [CAPACITY];
    logic [STORE_W-1:0] n_entries [CAPACITY];
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    // Registered result.
    t_status            r_status;
    t_status            n_status;
    logic [RDATA_W-1:0] r_rdata;
    logic [RDATA_W-1:0] n_rdata;

    logic [31:0]        pos_ext;
    logic [31:0]        cnt_ext;
    logic [STORE_W-1:0] rd_word;

    assign pos_ext = 32'(r_pos);
    assign cnt_ext = 32'(r_count);
    // Only used when the position is below the count, so it is in range.
    assign rd_word = r_entries[IDX_W'(r_pos)];

    always_comb begin
        n_status = ST_OK;
        if (r_op == OP_INSERT) begin
            if (pos_ext > cnt_ext) begin
                n_status = ST_RANGE;
            end else if (cnt_ext >= CAPACITY) begin
                n_status = ST_FULL;
            end
        end else if (r_count == '0) begin
            n_status = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
            n_status = ST_RANGE;
        end
    end

    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        n_rdata   = '0;
        if (n_status == ST_OK) begin
            case (r_op)
                OP_INSERT: begin
                    // Every entry above the gap takes its lower neighbor.
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (32'(i) > pos_ext) begin
                            n_entries[i] = r_entries[i-1];
                        end
                    end
                    // A successful insert has a position below the capacity.
                    n_entries[IDX_W'(r_pos)] = r_val;
                    n_count = r_count + CNT_W'(1);
                end
                OP_DELETE: begin
                    // Every entry from the position on takes its upper neighbor.
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (32'(i) >= pos_ext) begin
                            n_entries[i] = r_entries[i+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                    n_rdata = RDATA_W'(rd_word);
                end
                OP_UPDATE: begin
                    n_entries[IDX_W'(r_pos)] = r_val;
                end
                OP_SELECT: begin
                    n_rdata = RDATA_W'(rd_word);
                end
                default: begin
                    n_rdata = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= t_op'(i_func);
            r_pos <= i_position;
            r_val <= STORE_W'(i_value);
        end
        if (i_cmd.exec) begin
            r_entries <= n_entries;
            r_status  <= n_status;
            r_rdata   <= n_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status    = r_status;
    assign o_read_data = r_rdata;
    assign o_count     = COUNT_W'(r_count);

endmodule

### hw/rtl/indexed_insert_delete_list.sv
// Each accepted request beat is captured into the request registers and executed in
// the execute state, where the result registers are loaded; its result beat is then
// valid in the response state until it is taken.
// The three-state controller handles one request at a time, so a new request beat is
// accepted only once the previous result beat has been taken.
// Reset (synchronous, active low) empties the list and idles the controller; entry
// contents are not cleared, as no read can reach an entry at or above the count.
module indexed_insert_delete_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Request channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [iidl_pkg::FUNC_W-1:0]    i_func,
    input  logic [iidl_pkg::POS_W-1:0]     i_position,
    input  logic [iidl_pkg::VALUE_W-1:0]   i_value,
    // Result channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [iidl_pkg::STATUS_W-1:0]  o_status,
    output logic [iidl_pkg::RDATA_W-1:0]   o_read_data,
    output logic [iidl_pkg::COUNT_W-1:0]   o_count
);
    import iidl_pkg::*;

    // Commands from the controller to the datapath.
    t_cmd cmd;

    // The controller sequences each request through capture, execution and
    // result hand-off. It takes a new request beat only while idle.
    iidl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_out_ready (i_ready),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    // The datapath holds the list in a register array. Insert and delete move
    // all affected entries one place all together, each entry choosing
    // between itself, its neighbors and the new value. The bound checks
    // against the count and the result are registered in the execute cycle,
    // and the result registers hold steady while the result beat waits.
    iidl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_read_data (o_read_data),
        .o_count     (o_count)
    );

endmodule

### hw/rtl/iidl_chk.sv
module iidl_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [iidl_pkg::STATUS_W-1:0]  o_status,
    input logic [iidl_pkg::RDATA_W-1:0]   o_read_data,
    input logic [iidl_pkg::COUNT_W-1:0]   o_count
);
    import iidl_pkg::*;

    // An accepted request beat has its result beat up once the execute state is done.
    a_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |-> ##2 o_valid)
        else $error("result beat late after request");

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
            && $stable(o_read_data) && $stable(o_count)))
        else $error("result beat changed while stalled");

    // A failed request returns no data.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("failed request returned data");

    // An empty-list error implies a zero count.
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    // The count never exceeds the capacity.
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_count) <= CAPACITY))
        else $error("count above capacity");

endmodule

bind indexed_insert_delete_list iidl_chk u_iidl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_status    (o_status),
    .o_read_data (o_read_data),
    .o_count     (o_count)
);

### verif/tb_indexed_insert_delete_list.sv
`timescale 1ns / 100ps

module tb_indexed_insert_delete_list;
    import iidl_pkg::*;

    // Stimulus volume and pacing.
    localparam int RANDOM_ITEMS = 600;
    localparam int BURST_LEN    = 40;
    localparam int MAX_WAIT     = 4;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int POS_MAX      = (1 << POS_W) - 1;

    // Each random burst leans the operation mix one way so that the list
    // travels between empty and full instead of hovering near one size.
    typedef enum int {
        TREND_GROW,
        TREND_MIX,
        TREND_SHRINK
    } t_trend;

    typedef struct {
        t_op                op;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] value;
    } t_request;

    typedef struct {
        t_status            status;
        logic [RDATA_W-1:0] data;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic                o_ready;
    logic [FUNC_W-1:0]   i_func     = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic [VALUE_W-1:0]  i_value    = '0;
    logic                o_valid;
    logic                i_ready    = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [RDATA_W-1:0]  o_read_data;
    logic [COUNT_W-1:0]  o_count;

    // Our own copy of the list, advanced once per accepted request beat.
    logic [DATA_W-1:0] list_mem [CAPACITY];
    int                list_len = 0;

    // Requests still to be driven, and outcomes still to be seen on the
    // result channel, oldest first.
    t_request pending_requests[$];
    t_outcome expected_results[$];

    // Length the list will have once every queued request has run; the
    // generator uses it to aim positions at the live part of the list.
    int plan_len = 0;

    int   gap_left   = 0;
    int   stall_left = 0;
    bit   calm       = 1'b0;
    int   cycles     = 0;
    int   n_sent     = 0;
    int   n_checked  = 0;
    int   n_errors   = 0;
    int   deepest    = 0;
    int   status_hits [4] = '{0, 0, 0, 0};

    indexed_insert_delete_list uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_read_data (o_read_data),
        .o_count     (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the list copy and returns the result beat it
    // must produce. The order of the checks matters: for insert the position
    // is checked before fullness, and for the other operations emptiness is
    // checked before the position.
    function automatic t_outcome list_apply(t_request req);
        t_outcome res;
        int       p;
        int       i;
        p          = int'(req.pos);
        res.status = ST_OK;
        res.data   = '0;
        if (req.op == OP_INSERT) begin
            if (p > list_len) begin
                res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Open a gap at p by moving the tail up one place.
                for (i = list_len; i > p; i--) begin
                    list_mem[i] = list_mem[i - 1];
                end
                list_mem[p] = DATA_W'(req.value);
                list_len++;
            end
        end else if (list_len == 0) begin
            res.status = ST_EMPTY;
        end else if (p >= list_len) begin
            res.status = ST_RANGE;
        end else begin
            case (req.op)
                OP_DELETE: begin
                    // Hand out the entry, then close the gap behind it.
                    res.data = RDATA_W'(list_mem[p]);
                    for (i = p; i + 1 < list_len; i++) begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_len--;
                end
                OP_UPDATE: begin
                    list_mem[p] = DATA_W'(req.value);
                end
                default: begin
                    res.data = RDATA_W'(list_mem[p]);
                end
            endcase
        end
        res.count = COUNT_W'(list_len);
        return res;
    endfunction

    // Queues a request and tracks the length it leaves the list at.
    function automatic void queue_request(t_op op, int pos, logic [VALUE_W-1:0] value);
        t_request req;
        req.op    = op;
        req.pos   = POS_W'(pos);
        req.value = value;
        pending_requests.push_back(req);
        if (op == OP_INSERT && pos <= plan_len && plan_len < CAPACITY) begin
            plan_len++;
        end else if (op == OP_DELETE && pos < plan_len) begin
            plan_len--;
        end
    endfunction

    function automatic t_op pick_op(t_trend trend);
        int r;
        r = $urandom_range(0, 99);
        case (trend)
            TREND_GROW: begin
                if (r < 70) return OP_INSERT;
                if (r < 80) return OP_DELETE;
                if (r < 90) return OP_UPDATE;
                return OP_SELECT;
            end
            TREND_SHRINK: begin
                if (r < 70) return OP_DELETE;
                if (r < 80) return OP_INSERT;
                if (r < 90) return OP_UPDATE;
                return OP_SELECT;
            end
            default: return t_op'(r % 4);
        endcase
    endfunction

    // Mostly a position inside the live list (one past the end for insert),
    // sometimes anything the field can carry, which exercises the range error.
    function automatic int pick_position(t_op op);
        if ($urandom_range(0, 9) < 2 || (op != OP_INSERT && plan_len == 0)) begin
            return $urandom_range(0, POS_MAX);
        end
        if (op == OP_INSERT) begin
            return $urandom_range(0, plan_len);
        end
        return $urandom_range(0, plan_len - 1);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // Cycles a side waits before its next beat; zero throughout a calm stretch.
    function automatic int draw_wait();
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Calm stretches with no idling on either side come and go at random.
    always @(posedge i_clk) begin
        if ($urandom_range(0, 63) == 0) begin
            calm <= !calm;
        end
    end

    // Request driver. A beat that is up stays up, unchanged, until it is
    // accepted. Once it goes, the driver idles for a freshly drawn number of
    // cycles before it raises the next one. The prediction is made at the
    // accepting edge from the payload that the block actually took.
    always @(posedge i_clk) begin
        t_request taken;
        t_request next_req;
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && o_ready) begin
                taken.op    = t_op'(i_func);
                taken.pos   = i_position;
                taken.value = i_value;
                expected_results.push_back(list_apply(taken));
                if (list_len > deepest) begin
                    deepest = list_len;
                end
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left != 0 || pending_requests.size() == 0) begin
                    if (gap_left != 0) begin
                        gap_left <= gap_left - 1;
                    end
                    i_valid <= 1'b0;
                end else begin
                    next_req    = pending_requests.pop_front();
                    i_valid    <= 1'b1;
                    i_func     <= next_req.op;
                    i_position <= next_req.pos;
                    i_value    <= next_req.value;
                    gap_left   <= draw_wait();
                end
            end
        end
    end

    // Result monitor. Every beat taken is compared field by field with the
    // oldest outstanding prediction. Ready drops for a freshly drawn number of
    // cycles after each beat, whether or not the block has the next one yet.
    always @(posedge i_clk) begin
        t_outcome want;
        int       hold;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            hold = stall_left;
            if (o_valid && i_ready) begin
                hold = draw_wait();
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got status %0d data 0x%08h count %0d",
                             $time, o_status, o_read_data, o_count);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("read_data", 32'(want.data), 32'(o_read_data));
                    check_field("count", 32'(want.count), 32'(o_count));
                    status_hits[want.status]++;
                    n_checked++;
                end
            end
            if (hold != 0) begin
                i_ready    <= 1'b0;
                stall_left <= hold - 1;
            end else begin
                i_ready    <= 1'b1;
                stall_left <= 0;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d requests and %0d results outstanding",
                     $time, pending_requests.size(), expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_trend trend;
        t_op    op;
        int     b;
        int     k;

        // Operations on an empty list, and inserts past the end of it.
        queue_request(OP_SELECT, 0, '0);
        queue_request(OP_DELETE, 0, '0);
        queue_request(OP_UPDATE, 5, 32'hDEADBEEF);
        queue_request(OP_INSERT, 1, 32'h11111111);
        queue_request(OP_INSERT, POS_MAX, 32'h22222222);
        // Build a short list with inserts at the end, the front and the middle.
        queue_request(OP_INSERT, 0, 32'h00000000);
        queue_request(OP_INSERT, 1, 32'hFFFFFFFF);
        queue_request(OP_INSERT, 0, 32'hA5A5A5A5);
        queue_request(OP_INSERT, 1, 32'h5A5A5A5A);
        // Reads at the last entry, one past it, and a position with the top bit set.
        queue_request(OP_SELECT, 3, '0);
        queue_request(OP_SELECT, 4, '0);
        queue_request(OP_SELECT, 16, '0);
        queue_request(OP_UPDATE, 2, 32'h12345678);
        queue_request(OP_UPDATE, 4, 32'h87654321);
        queue_request(OP_SELECT, 2, '0);
        // Deletes in the middle, past the end and at the end, then drain to empty.
        queue_request(OP_DELETE, 1, '0);
        queue_request(OP_DELETE, 3, '0);
        queue_request(OP_DELETE, 2, '0);
        queue_request(OP_SELECT, 0, '0);
        queue_request(OP_DELETE, 0, '0);
        queue_request(OP_DELETE, 0, '0);
        queue_request(OP_DELETE, 0, '0);

        // Random bursts cycle grow, mix, shrink, mix, so the list repeatedly
        // fills up (full errors) and drains out (empty errors).
        for (b = 0; b < RANDOM_ITEMS / BURST_LEN; b++) begin
            case (b % 4)
                0:       trend = TREND_GROW;
                2:       trend = TREND_SHRINK;
                default: trend = TREND_MIX;
            endcase
            for (k = 0; k < BURST_LEN; k++) begin
                op = pick_op(trend);
                queue_request(op, pick_position(op), pick_value());
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (pending_requests.size() != 0 || i_valid || expected_results.size() != 0);
        // Give a stray extra result beat time to show up.
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d requests and checked %0d results; list reached %0d of %0d entries.",
                 n_sent, n_checked, deepest, CAPACITY);
        $display("Statuses seen: ok %0d, out of range %0d, empty %0d, full %0d.",
                 status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_EMPTY],
                 status_hits[ST_FULL]);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
